FILE: rtl/pixel_neighbour_predictor_core_defines.svh
// Assertion macros used by the pixel predictor port checker.
`ifndef PIXEL_NEIGHBOUR_PREDICTOR_CORE_DEFINES_SVH
`define PIXEL_NEIGHBOUR_PREDICTOR_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is low.
`define PNP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("pnp same-cycle check failed");

// Next-cycle implication, off while reset is low.
`define PNP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("pnp next-cycle check failed");

// Next-cycle implication that also runs through reset.
`define PNP_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pnp reset check failed");

`endif

FILE: rtl/pnp_pkg.sv
// Shared types and constants of the pixel neighbour predictor.
package pnp_pkg;

  localparam int PIXEL_BITS_DEF = 8;
  localparam int MODE_BITS      = 2;

  // Gradient thresholds of the gradient-adjusted predictor.
  localparam int GAP_T_HI  = 80;
  localparam int GAP_T_MID = 32;
  localparam int GAP_T_LO  = 8;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_MED   = 2'd0,
    MODE_PAETH = 2'd1,
    MODE_GAP   = 2'd2
  } mode_t;

endpackage

FILE: rtl/pixel_neighbour_predictor_core.sv
// Pixel neighbour predictor: MED, Paeth and gradient-adjusted prediction.
//
// Input channel (in_*): one word per pixel carrying its seven causal
// neighbours. A word is taken at a rising edge with in_valid high and
// in_stall low. Output channel (out_*): one word per input word with the
// prediction and the clipped flag, taken when out_valid is high and
// out_stall is low.
// Configuration (cfg_*): cfg_predictor_mode selects 0 MED, 1 Paeth,
// 2 gradient-adjusted; code 3 acts as MED. cfg_ready is always high; write
// only while no word is in flight.
// A taken word passes through the input register and then the output register.
// Throughput: one word per cycle while out_stall is low; the input register
// feeds one pass of combinational logic into the output register.
// Stall: a stalled output word holds; the input register keeps one more word,
// and in_stall rises only when both registers are full and out_stall is high.
// Reset: both valid flags clear and the mode returns to MED.
module pixel_neighbour_predictor_core #(
  parameter int PIXEL_BITS = pnp_pkg::PIXEL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [PIXEL_BITS-1:0]          in_west_pixel,
  input  logic [PIXEL_BITS-1:0]          in_north_pixel,
  input  logic [PIXEL_BITS-1:0]          in_northwest_pixel,
  input  logic [PIXEL_BITS-1:0]          in_northeast_pixel,
  input  logic [PIXEL_BITS-1:0]          in_westwest_pixel,
  input  logic [PIXEL_BITS-1:0]          in_northnorth_pixel,
  input  logic [PIXEL_BITS-1:0]          in_northnortheast_pixel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [PIXEL_BITS-1:0]          out_prediction,
  output logic                           out_clipped,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pnp_pkg::MODE_BITS-1:0]  cfg_predictor_mode
);
  import pnp_pkg::*;

  localparam int SW = PIXEL_BITS + 4;
  localparam logic signed [SW-1:0] T_HI  = SW'(GAP_T_HI);
  localparam logic signed [SW-1:0] T_MID = SW'(GAP_T_MID);
  localparam logic signed [SW-1:0] T_LO  = SW'(GAP_T_LO);
  localparam logic signed [SW-1:0] PIX_MAX = $signed({4'b0000, {PIXEL_BITS{1'b1}}});

  mode_t                  mode_r;
  logic                   s1_valid_r;
  logic [PIXEL_BITS-1:0]  w_r, n_r, nw_r, ne_r, ww_r, nn_r, nne_r;
  logic                   out_valid_r;
  logic [PIXEL_BITS-1:0]  pred_r;
  logic                   clip_r;
  logic [PIXEL_BITS-1:0]  pred_nxt;
  logic                   clip_nxt;
  logic                   out_load;
  logic                   in_take;

  logic signed [SW-1:0] w_s, n_s, nw_s, ne_s, ww_s, nn_s, nne_s;
  logic signed [SW-1:0] med_v, paeth_v, gap_v;
  logic signed [SW-1:0] lo_v, hi_v;
  logic signed [SW-1:0] dw, dn, dnw;
  logic signed [SW-1:0] dh, dv, grad, base_v;

  function automatic logic signed [SW-1:0] absd(input logic signed [SW-1:0] a,
                                                input logic signed [SW-1:0] b);
    absd = (a > b) ? (a - b) : (b - a);
  endfunction

  // Divide by 2 or 4 with truncation toward zero.
  function automatic logic signed [SW-1:0] div2t(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] bias;
    bias = x[SW-1] ? SW'(1) : SW'(0);
    div2t = (x + bias) >>> 1;
  endfunction

  function automatic logic signed [SW-1:0] div4t(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] bias;
    bias = x[SW-1] ? SW'(3) : SW'(0);
    div4t = (x + bias) >>> 2;
  endfunction

  assign cfg_ready = 1'b1;
  assign out_load  = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_load;
  assign in_take   = in_valid && !in_stall;

  assign out_valid      = out_valid_r;
  assign out_prediction = pred_r;
  assign out_clipped    = clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_MED;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= mode_t'(cfg_predictor_mode);
      end
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      w_r   <= in_west_pixel;
      n_r   <= in_north_pixel;
      nw_r  <= in_northwest_pixel;
      ne_r  <= in_northeast_pixel;
      ww_r  <= in_westwest_pixel;
      nn_r  <= in_northnorth_pixel;
      nne_r <= in_northnortheast_pixel;
    end
    if (out_load && s1_valid_r) begin
      pred_r <= pred_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign w_s   = $signed({4'b0000, w_r});
  assign n_s   = $signed({4'b0000, n_r});
  assign nw_s  = $signed({4'b0000, nw_r});
  assign ne_s  = $signed({4'b0000, ne_r});
  assign ww_s  = $signed({4'b0000, ww_r});
  assign nn_s  = $signed({4'b0000, nn_r});
  assign nne_s = $signed({4'b0000, nne_r});

  // Median edge detection.
  always_comb begin
    lo_v = (w_s > n_s) ? n_s : w_s;
    hi_v = (w_s > n_s) ? w_s : n_s;
    if (nw_s > hi_v) begin
      med_v = lo_v;
    end else if (nw_s < lo_v) begin
      med_v = hi_v;
    end else begin
      med_v = w_s + n_s - nw_s;
    end
  end

  // Paeth.
  always_comb begin
    dw  = absd(n_s, nw_s);
    dn  = absd(w_s, nw_s);
    dnw = absd(w_s + n_s, nw_s <<< 1);
    if (dw <= dn && dw <= dnw) begin
      paeth_v = w_s;
    end else if (dn <= dnw) begin
      paeth_v = n_s;
    end else begin
      paeth_v = nw_s;
    end
  end

  // Gradient-adjusted prediction, unsaturated.
  always_comb begin
    dh     = absd(w_s, ww_s) + absd(n_s, nw_s) + absd(ne_s, n_s);
    dv     = absd(w_s, nw_s) + absd(n_s, nn_s) + absd(ne_s, nne_s);
    grad   = dv - dh;
    base_v = div2t(w_s + n_s) + div4t(ne_s - nw_s);
    if (grad > T_HI) begin
      gap_v = w_s;
    end else if (grad < -T_HI) begin
      gap_v = n_s;
    end else if (grad > T_MID) begin
      gap_v = div2t(base_v + w_s);
    end else if (grad > T_LO) begin
      gap_v = div4t((base_v <<< 1) + base_v + w_s);
    end else if (grad < -T_MID) begin
      gap_v = div2t(base_v + n_s);
    end else if (grad < -T_LO) begin
      gap_v = div4t((base_v <<< 1) + base_v + n_s);
    end else begin
      gap_v = base_v;
    end
  end

  always_comb begin
    clip_nxt = 1'b0;
    case (mode_r)
      MODE_PAETH: pred_nxt = paeth_v[PIXEL_BITS-1:0];
      MODE_GAP: begin
        if (gap_v < 0) begin
          pred_nxt = '0;
          clip_nxt = 1'b1;
        end else if (gap_v > PIX_MAX) begin
          pred_nxt = '1;
          clip_nxt = 1'b1;
        end else begin
          pred_nxt = gap_v[PIXEL_BITS-1:0];
        end
      end
      default: pred_nxt = med_v[PIXEL_BITS-1:0];
    endcase
  end

endmodule

FILE: rtl/pnp_checker.sv
// Port-level checks of the pixel neighbour predictor and their bind.
`include "pixel_neighbour_predictor_core_defines.svh"

module pnp_checker #(
  parameter int PIXEL_BITS = pnp_pkg::PIXEL_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [PIXEL_BITS-1:0] out_prediction,
  input logic                  out_clipped
);

  // A clipped word sits on one of the two rails.
  `PNP_ASSERT_IMP(a_clip_rail, clk, rst_n, out_valid && out_clipped, out_prediction == '0 || out_prediction == '1)

  // Input backs up only behind a stalled, full output.
  `PNP_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

  // Hold a stalled output word.
  `PNP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_prediction) && $stable(out_clipped))

  // Reset drops the output.
  `PNP_ASSERT_NXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid && !in_stall)

endmodule

bind pixel_neighbour_predictor_core pnp_checker #(
  .PIXEL_BITS(PIXEL_BITS)
) u_pnp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_prediction(out_prediction),
  .out_clipped   (out_clipped)
);

FILE: test/pixel_neighbour_predictor_checker.sv
// Prediction checker: tracks the mode, predicts each word and compares results.
module pixel_neighbour_predictor_checker #(
  parameter int PIXEL_BITS = pnp_pkg::PIXEL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [PIXEL_BITS-1:0]          in_west_pixel,
  input  logic [PIXEL_BITS-1:0]          in_north_pixel,
  input  logic [PIXEL_BITS-1:0]          in_northwest_pixel,
  input  logic [PIXEL_BITS-1:0]          in_northeast_pixel,
  input  logic [PIXEL_BITS-1:0]          in_westwest_pixel,
  input  logic [PIXEL_BITS-1:0]          in_northnorth_pixel,
  input  logic [PIXEL_BITS-1:0]          in_northnortheast_pixel,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [PIXEL_BITS-1:0]          out_prediction,
  input  logic                           out_clipped,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [pnp_pkg::MODE_BITS-1:0]  cfg_predictor_mode,
  output int                             mismatch_count,
  output int                             pending_predictions,
  output int                             checked_predictions,
  output int                             saturated_predictions
);
  timeunit 1ns;
  timeprecision 1ps;

  import pnp_pkg::*;

  localparam int PIX_MAX = (1 << PIXEL_BITS) - 1;
  localparam int PRINT_CAP = 20;

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef struct packed {
    pixel_t value;
    logic   clipped;
  } prediction_t;

  logic [MODE_BITS-1:0] mode_shadow;
  prediction_t          expected_q[$];

  function automatic int pixel_distance(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int median_edge(input int w, input int n, input int nw);
    int lo, hi;
    lo = (w > n) ? n : w;
    hi = (w > n) ? w : n;
    if (nw > hi) return lo;
    if (nw < lo) return hi;
    return w + n - nw;
  endfunction

  function automatic int paeth(input int w, input int n, input int nw);
    int dw, dn, dnw;
    dw  = pixel_distance(n, nw);
    dn  = pixel_distance(w, nw);
    dnw = pixel_distance(w + n, 2 * nw);
    if (dw <= dn && dw <= dnw) return w;
    return (dn <= dnw) ? n : nw;
  endfunction

  // Signed division here truncates toward zero, as the predictor requires.
  function automatic int gradient_adjusted(input int w, input int n, input int nw,
                                           input int ne, input int ww, input int nn,
                                           input int nne);
    int dh, dv, grad, v;
    dh = pixel_distance(w, ww) + pixel_distance(n, nw) + pixel_distance(ne, n);
    dv = pixel_distance(w, nw) + pixel_distance(n, nn) + pixel_distance(ne, nne);
    grad = dv - dh;
    if (grad > GAP_T_HI) return w;
    if (grad < -GAP_T_HI) return n;
    v = (w + n) / 2 + (ne - nw) / 4;
    if (grad > GAP_T_MID)       v = (v + w) / 2;
    else if (grad > GAP_T_LO)   v = (3 * v + w) / 4;
    else if (grad < -GAP_T_MID) v = (v + n) / 2;
    else if (grad < -GAP_T_LO)  v = (3 * v + n) / 4;
    return v;
  endfunction

  function automatic prediction_t predict_pixel(input logic [MODE_BITS-1:0] mode,
                                                input int w, input int n, input int nw,
                                                input int ne, input int ww, input int nn,
                                                input int nne);
    prediction_t r;
    int p;
    r.clipped = 1'b0;
    case (mode)
      MODE_PAETH: p = paeth(w, n, nw);
      MODE_GAP: begin
        p = gradient_adjusted(w, n, nw, ne, ww, nn, nne);
        if (p < 0) begin
          p = 0;
          r.clipped = 1'b1;
        end else if (p > PIX_MAX) begin
          p = PIX_MAX;
          r.clipped = 1'b1;
        end
      end
      // the unused code falls back to median edge detection
      default: p = median_edge(w, n, nw);
    endcase
    r.value = pixel_t'(p);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("%0t: mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin : track
    prediction_t want;
    if (!rst_n) begin
      mode_shadow = MODE_MED;
      expected_q.delete();
      mismatch_count = 0;
      checked_predictions = 0;
      saturated_predictions = 0;
    end else begin
      if (cfg_valid && cfg_ready) mode_shadow = cfg_predictor_mode;
      // retire before queueing so a stray word cannot match a fresh prediction
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("prediction %0d arrived with none outstanding",
                                    out_prediction));
        end else begin
          want = expected_q.pop_front();
          checked_predictions++;
          if (want.clipped) saturated_predictions++;
          if (out_prediction !== want.value)
            report_mismatch($sformatf("mode %0d prediction got %0d expected %0d",
                                      mode_shadow, out_prediction, want.value));
          if (out_clipped !== want.clipped)
            report_mismatch($sformatf("mode %0d clipped got %b expected %b",
                                      mode_shadow, out_clipped, want.clipped));
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(predict_pixel(mode_shadow, int'(in_west_pixel),
                                           int'(in_north_pixel),
                                           int'(in_northwest_pixel),
                                           int'(in_northeast_pixel),
                                           int'(in_westwest_pixel),
                                           int'(in_northnorth_pixel),
                                           int'(in_northnortheast_pixel)));
    end
    pending_predictions <= expected_q.size();
  end

endmodule

FILE: test/pixel_neighbour_predictor_core_test.sv
// Testbench top: drives neighbourhoods and mode writes, gives the verdict.
module pixel_neighbour_predictor_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pnp_pkg::*;

  localparam int PIXEL_BITS = PIXEL_BITS_DEF;
  localparam int PIX_MAX = (1 << PIXEL_BITS) - 1;
  localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;
  localparam int SEGMENT_WORDS = 160;
  localparam int HOLD_OFF_CYCLES = 48;
  localparam int QUIET_LIMIT = 2000;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  pixel_t               in_west_pixel;
  pixel_t               in_north_pixel;
  pixel_t               in_northwest_pixel;
  pixel_t               in_northeast_pixel;
  pixel_t               in_westwest_pixel;
  pixel_t               in_northnorth_pixel;
  pixel_t               in_northnortheast_pixel;
  logic                 out_valid;
  logic                 out_stall;
  pixel_t               out_prediction;
  logic                 out_clipped;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [MODE_BITS-1:0] cfg_predictor_mode;

  int   mismatch_count;
  int   pending_predictions;
  int   checked_predictions;
  int   saturated_predictions;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   words_sent;
  int   held_offers;
  logic hold_request;

  pixel_neighbour_predictor_core #(.PIXEL_BITS(PIXEL_BITS)) DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_west_pixel           (in_west_pixel),
    .in_north_pixel          (in_north_pixel),
    .in_northwest_pixel      (in_northwest_pixel),
    .in_northeast_pixel      (in_northeast_pixel),
    .in_westwest_pixel       (in_westwest_pixel),
    .in_northnorth_pixel     (in_northnorth_pixel),
    .in_northnortheast_pixel (in_northnortheast_pixel),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_prediction          (out_prediction),
    .out_clipped             (out_clipped),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_predictor_mode      (cfg_predictor_mode)
  );

  pixel_neighbour_predictor_checker #(.PIXEL_BITS(PIXEL_BITS)) prediction_check (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_west_pixel           (in_west_pixel),
    .in_north_pixel          (in_north_pixel),
    .in_northwest_pixel      (in_northwest_pixel),
    .in_northeast_pixel      (in_northeast_pixel),
    .in_westwest_pixel       (in_westwest_pixel),
    .in_northnorth_pixel     (in_northnorth_pixel),
    .in_northnortheast_pixel (in_northnortheast_pixel),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_prediction          (out_prediction),
    .out_clipped             (out_clipped),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_predictor_mode      (cfg_predictor_mode),
    .mismatch_count          (mismatch_count),
    .pending_predictions     (pending_predictions),
    .checked_predictions     (checked_predictions),
    .saturated_predictions   (saturated_predictions)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall) held_offers++;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int   hold_left;
    logic hold_served;
    hold_left = 0;
    hold_served = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_served) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_served = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("no handshake for %0d cycles, giving up", QUIET_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  function automatic pixel_t pixel_near(input int centre, input int spread);
    int v;
    v = centre + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > PIX_MAX) v = PIX_MAX;
    return pixel_t'(v);
  endfunction

  task automatic drive_neighbourhood(input pixel_t w, input pixel_t n, input pixel_t nw,
                                     input pixel_t ne, input pixel_t ww, input pixel_t nn,
                                     input pixel_t nne);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid                <= 1'b1;
    in_west_pixel           <= w;
    in_north_pixel          <= n;
    in_northwest_pixel      <= nw;
    in_northeast_pixel      <= ne;
    in_westwest_pixel       <= ww;
    in_northnorth_pixel     <= nn;
    in_northnortheast_pixel <= nne;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Drop valid, wait until every word has come back, then write the mode.
  task automatic set_mode(input logic [MODE_BITS-1:0] mode);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_predictions != 0) @(posedge clk);
    cfg_valid          <= 1'b1;
    cfg_predictor_mode <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_directed_set();
    pixel_t z, m;
    z = '0;
    m = pixel_t'(PIX_MAX);
    drive_neighbourhood(z, z, z, z, z, z, z);
    drive_neighbourhood(m, m, m, m, m, m, m);
    // flat gradient with a dark corner pushes the gradient value above range
    drive_neighbourhood(m, m, z, m, m, m, m);
    // and a bright corner pushes it below zero
    drive_neighbourhood(z, z, m, z, z, z, z);
    // sharp horizontal edge, then sharp vertical edge
    drive_neighbourhood(8'd200, 8'd10, 8'd10, 8'd10, 8'd200, 8'd250, 8'd250);
    drive_neighbourhood(z, m, z, z, m, m, z);
  endtask

  task automatic send_random_neighbourhood();
    pixel_t px[7];
    int     base;
    logic   bright;
    case ($urandom_range(3))
      0: begin
        foreach (px[i]) px[i] = pixel_t'($urandom);
      end
      1: begin
        base = $urandom_range(PIX_MAX);
        foreach (px[i]) px[i] = pixel_near(base, 12);
      end
      2: begin
        // near-flat area at one extreme with the north-west corner at the other
        bright = 1'($urandom_range(1));
        foreach (px[i]) px[i] = pixel_near(bright ? PIX_MAX : 0, 6);
        px[2] = pixel_near(bright ? 0 : PIX_MAX, 6);
      end
      default: begin
        foreach (px[i]) begin
          case ($urandom_range(2))
            0: px[i] = '0;
            1: px[i] = pixel_t'(PIX_MAX);
            default: px[i] = pixel_t'($urandom);
          endcase
        end
      end
    endcase
    drive_neighbourhood(px[0], px[1], px[2], px[3], px[4], px[5], px[6]);
  endtask

  initial begin
    logic [MODE_BITS-1:0] mode_order[4];
    mode_order = '{MODE_MED, MODE_PAETH, MODE_GAP, MODE_SPARE};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    words_sent = 0;
    held_offers = 0;
    rst_n                   <= 1'b0;
    in_valid                <= 1'b0;
    in_west_pixel           <= '0;
    in_north_pixel          <= '0;
    in_northwest_pixel      <= '0;
    in_northeast_pixel      <= '0;
    in_westwest_pixel       <= '0;
    in_northnorth_pixel     <= '0;
    in_northnortheast_pixel <= '0;
    cfg_valid               <= 1'b0;
    cfg_predictor_mode      <= MODE_MED;
    hold_request            <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // first set runs on the mode left by reset
    send_directed_set();
    for (int k = 1; k < 4; k++) begin
      set_mode(mode_order[k]);
      send_directed_set();
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        set_mode(mode_order[(seg + phase) % 4]);
        if (phase == 2 && seg == 0) hold_request <= 1'b1;
        repeat (SEGMENT_WORDS) send_random_neighbourhood();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_predictions != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d neighbourhoods under MED, Paeth, GAP and the spare mode code;",
             words_sent);
    $display("checked %0d predictions, %0d saturated, input held off on %0d cycles.",
             checked_predictions, saturated_predictions, held_offers);
    if (mismatch_count == 0 && pending_predictions == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
